### src/blit_clip_setup_assert.svh
// Assertion macros shared by the blit clip setup checkers.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BLIT_CLIP_SETUP_ASSERT_SVH
`define BLIT_CLIP_SETUP_ASSERT_SVH

// Checked only while out of reset.
`define BCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/bcs_pkg.sv
// Package for the blit clip setup block: widths, register indexes,
// stream packing positions and the structs passed between stages. No dependencies.
package bcs_pkg;

  localparam int COORD_BITS  = 16;
  localparam int ADDR_BITS   = 32;
  localparam int REG_FIELD_W = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_REGS    = 7;

  // Internal coordinate width: room for sums of clip offsets and sizes.
  localparam int CALC_W = ((COORD_BITS > REG_FIELD_W) ? COORD_BITS : REG_FIELD_W) + 4;
  localparam int PROD_W = CALC_W + REG_FIELD_W + 1;

  localparam int PIX_W  = 32;
  localparam int SIZE_W = 15;
  localparam int SKIP_W = 16;

  // Input stream packing.
  localparam int IN_DX_LSB   = 0;
  localparam int IN_DY_LSB   = COORD_BITS;
  localparam int IN_SX_LSB   = 2 * COORD_BITS;
  localparam int IN_SY_LSB   = 3 * COORD_BITS;
  localparam int IN_W_LSB    = 4 * COORD_BITS;
  localparam int IN_H_LSB    = 5 * COORD_BITS;
  localparam int IN_DATA_W   = ((6 * COORD_BITS + 7) / 8) * 8;

  // Output stream packing.
  localparam int OUT_DST_LSB = 0;
  localparam int OUT_SRC_LSB = PIX_W;
  localparam int OUT_CW_LSB  = 2 * PIX_W;
  localparam int OUT_CH_LSB  = OUT_CW_LSB + SIZE_W;
  localparam int OUT_DSK_LSB = OUT_CH_LSB + SIZE_W;
  localparam int OUT_SSK_LSB = OUT_DSK_LSB + SKIP_W;
  localparam int OUT_USED_W  = OUT_SSK_LSB + SKIP_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DST_CLIP_START  = 3'd0,
    REG_DST_CLIP_END    = 3'd1,
    REG_SRC_AREA_ORIGIN = 3'd2,
    REG_SRC_AREA_SIZE   = 3'd3,
    REG_ROW_PITCHES     = 3'd4,
    REG_DST_BASE        = 3'd5,
    REG_SRC_BASE        = 3'd6
  } reg_idx_t;

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [CALC_W-1:0]     calc_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [REG_FIELD_W-1:0]       field_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_word_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;
  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic [SIZE_W-1:0]            size_t;
  typedef logic [SKIP_W-1:0]            skip_t;

  // Decoded configuration, as seen by the pipeline.
  typedef struct packed {
    calc_t  cx0;
    calc_t  cy0;
    calc_t  cx1;
    calc_t  cy1;
    calc_t  ax0;
    calc_t  ay0;
    calc_t  ax1;
    calc_t  ay1;
    field_t dpitch;
    field_t spitch;
    addr_t  dbase;
    addr_t  sbase;
  } cfg_t;

  // Command state through the clipping stages.
  typedef struct packed {
    calc_t dx;
    calc_t dy;
    calc_t sx;
    calc_t sy;
    calc_t w;
    calc_t h;
    logic  rej;
  } clip_t;

  // Result item.
  typedef struct packed {
    logic  accepted;
    pix_t  dst_start;
    pix_t  src_start;
    size_t clipped_width;
    size_t clipped_height;
    skip_t dst_row_skip;
    skip_t src_row_skip;
  } res_t;

endpackage

### src/blit_clip_setup.sv
// Top level of the blit clip setup block: configuration registers, the
// clipping pipeline and the address pipeline. Uses bcs_pkg and the three submodules.
//
// Usage: each command transfer on the in_ channel carries a rectangle copy
// (destination corner, source corner, width, height). The block clips it
// against the destination clip rectangle, then against the source area,
// and returns exactly one result transfer on the out_ channel per command,
// in command order. out_tuser is 1 for a copy that remains and 0 for a
// rejected one; a rejected result has all of out_tdata at zero.
// An input transfer reaches out_tvalid through eight registered stages: five
// clipping stages, a multiply stage, an address sum stage and the output register.
// The block takes one command per cycle while the output is not stalled; every
// stage holds one command and moves on whenever the stage after it is empty or moving.
// When the receiver holds out_tready low, the result stays on the port and
// the stages behind it fill up; in_tready falls only once all eight are full,
// and it rises again in the cycle the output is taken.
// The cfg_ channel is always ready. A write reaches the pipeline through the
// register file and its registered decode; writes to indexes past the last
// register are dropped. Reset zeroes the config registers and empties the pipeline.
module blit_clip_setup (
  input  logic                           clk,
  input  logic                           rst_n,
  // Commands. in_tdata fields from bit 0 up: dest_x, dest_y, source_x,
  // source_y, copy_width, copy_height (16 bits each, signed).
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // Results. out_tdata fields from bit 0 up: dst_start (32), src_start (32),
  // clipped_width (15), clipped_height (15), dst_row_skip (16),
  // src_row_skip (16), then two zero bits.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bcs_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: accepted.
  output logic [0:0]                     out_tuser,
  // Register writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  bcs_pkg::cfg_word_t             cfg_data
);

  bcs_pkg::cfg_t  cfg;
  bcs_pkg::clip_t clip_cmd;
  bcs_pkg::res_t  res;
  logic           clip_valid;
  logic           clip_ready;

  assign cfg_ready = 1'b1;

  bcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  bcs_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (clip_valid),
    .dn_ready (clip_ready),
    .dn_cmd   (clip_cmd)
  );

  bcs_addr u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (clip_valid),
    .up_ready (clip_ready),
    .up_cmd   (clip_cmd),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (res)
  );

  // Pack the result fields; the padding bits stay zero.
  always_comb begin
    out_tdata = '0;
    out_tdata[bcs_pkg::OUT_DST_LSB +: bcs_pkg::PIX_W]  = res.dst_start;
    out_tdata[bcs_pkg::OUT_SRC_LSB +: bcs_pkg::PIX_W]  = res.src_start;
    out_tdata[bcs_pkg::OUT_CW_LSB  +: bcs_pkg::SIZE_W] = res.clipped_width;
    out_tdata[bcs_pkg::OUT_CH_LSB  +: bcs_pkg::SIZE_W] = res.clipped_height;
    out_tdata[bcs_pkg::OUT_DSK_LSB +: bcs_pkg::SKIP_W] = res.dst_row_skip;
    out_tdata[bcs_pkg::OUT_SSK_LSB +: bcs_pkg::SKIP_W] = res.src_row_skip;
    out_tuser[0] = res.accepted;
  end

endmodule

### src/bcs_cfg_regs.sv
// Configuration register file of the blit clip setup block.
// Holds the seven registers and a registered decode of them. Uses bcs_pkg.
module bcs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  bcs_pkg::cfg_word_t          cfg_data,
  output bcs_pkg::cfg_t               cfg_o
);

  bcs_pkg::cfg_word_t cfg_r [bcs_pkg::NUM_REGS];
  bcs_pkg::cfg_t      dec_nxt;
  bcs_pkg::cfg_t      dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bcs_pkg::NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_valid && (32'(cfg_index) < 32'(bcs_pkg::NUM_REGS))) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Coordinates are 16-bit signed halves; sizes and pitches are unsigned.
  always_comb begin
    dec_nxt.cx0 = bcs_pkg::calc_t'($signed(cfg_r[bcs_pkg::REG_DST_CLIP_START][15:0]));
    dec_nxt.cy0 = bcs_pkg::calc_t'($signed(cfg_r[bcs_pkg::REG_DST_CLIP_START][31:16]));
    dec_nxt.cx1 = bcs_pkg::calc_t'($signed(cfg_r[bcs_pkg::REG_DST_CLIP_END][15:0]));
    dec_nxt.cy1 = bcs_pkg::calc_t'($signed(cfg_r[bcs_pkg::REG_DST_CLIP_END][31:16]));
    dec_nxt.ax0 = bcs_pkg::calc_t'($signed(cfg_r[bcs_pkg::REG_SRC_AREA_ORIGIN][15:0]));
    dec_nxt.ay0 = bcs_pkg::calc_t'($signed(cfg_r[bcs_pkg::REG_SRC_AREA_ORIGIN][31:16]));
    dec_nxt.ax1 = dec_nxt.ax0
                + bcs_pkg::calc_t'($signed({1'b0, cfg_r[bcs_pkg::REG_SRC_AREA_SIZE][15:0]}))
                - bcs_pkg::calc_t'(1);
    dec_nxt.ay1 = dec_nxt.ay0
                + bcs_pkg::calc_t'($signed({1'b0, cfg_r[bcs_pkg::REG_SRC_AREA_SIZE][31:16]}))
                - bcs_pkg::calc_t'(1);
    dec_nxt.dpitch = cfg_r[bcs_pkg::REG_ROW_PITCHES][15:0];
    dec_nxt.spitch = cfg_r[bcs_pkg::REG_ROW_PITCHES][31:16];
    dec_nxt.dbase  = bcs_pkg::addr_t'(cfg_r[bcs_pkg::REG_DST_BASE]);
    dec_nxt.sbase  = bcs_pkg::addr_t'(cfg_r[bcs_pkg::REG_SRC_BASE]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= '0;
    end else begin
      dec_r <= dec_nxt;
    end
  end

  assign cfg_o = dec_r;

endmodule

### src/bcs_clip.sv
// Clipping pipeline of the blit clip setup block: input capture, start
// clipping (destination then source) and end clipping. Uses bcs_pkg.
module bcs_clip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcs_pkg::cfg_t                 cfg,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [bcs_pkg::IN_DATA_W-1:0] up_data,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output bcs_pkg::clip_t                dn_cmd
);

  localparam int NS = 5;

  logic [NS-1:0]  vld_r;
  logic [NS-1:0]  adv;

  bcs_pkg::clip_t s0_nxt, s1_nxt, s2_nxt, s3_nxt, s4_nxt;
  bcs_pkg::clip_t s0_r, s1_r, s2_r, s3_r, s4_r;
  bcs_pkg::calc_t dlx, dly, ex, ey;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 0: unpack the command.
  always_comb begin
    s0_nxt.dx  = bcs_pkg::calc_t'(bcs_pkg::crd_t'(
                   up_data[bcs_pkg::IN_DX_LSB +: bcs_pkg::COORD_BITS]));
    s0_nxt.dy  = bcs_pkg::calc_t'(bcs_pkg::crd_t'(
                   up_data[bcs_pkg::IN_DY_LSB +: bcs_pkg::COORD_BITS]));
    s0_nxt.sx  = bcs_pkg::calc_t'(bcs_pkg::crd_t'(
                   up_data[bcs_pkg::IN_SX_LSB +: bcs_pkg::COORD_BITS]));
    s0_nxt.sy  = bcs_pkg::calc_t'(bcs_pkg::crd_t'(
                   up_data[bcs_pkg::IN_SY_LSB +: bcs_pkg::COORD_BITS]));
    s0_nxt.w   = bcs_pkg::calc_t'(bcs_pkg::crd_t'(
                   up_data[bcs_pkg::IN_W_LSB +: bcs_pkg::COORD_BITS]));
    s0_nxt.h   = bcs_pkg::calc_t'(bcs_pkg::crd_t'(
                   up_data[bcs_pkg::IN_H_LSB +: bcs_pkg::COORD_BITS]));
    s0_nxt.rej = 1'b0;
  end

  // Stage 1: early reject, then move the start into the destination clip.
  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.rej = (s0_r.dx > cfg.cx1) || (s0_r.dy > cfg.cy1)
              || (s0_r.sx > cfg.ax1) || (s0_r.sy > cfg.ay1);
    dlx = cfg.cx0 - s0_r.dx;
    dly = cfg.cy0 - s0_r.dy;
    if (s0_r.dx < cfg.cx0) begin
      s1_nxt.w  = s0_r.w - dlx;
      s1_nxt.sx = s0_r.sx + dlx;
      s1_nxt.dx = cfg.cx0;
    end
    if (s0_r.dy < cfg.cy0) begin
      s1_nxt.h  = s0_r.h - dly;
      s1_nxt.sy = s0_r.sy + dly;
      s1_nxt.dy = cfg.cy0;
    end
    s1_nxt.rej = s1_nxt.rej || (s1_nxt.sx > cfg.ax1) || (s1_nxt.sy > cfg.ay1);
  end

  // Stage 2: move the start into the source area.
  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.sx < cfg.ax0) begin
      s2_nxt.w  = s1_r.w - (cfg.ax0 - s1_r.sx);
      s2_nxt.dx = s1_r.dx + (cfg.ax0 - s1_r.sx);
      s2_nxt.sx = cfg.ax0;
    end
    if (s1_r.sy < cfg.ay0) begin
      s2_nxt.h  = s1_r.h - (cfg.ay0 - s1_r.sy);
      s2_nxt.dy = s1_r.dy + (cfg.ay0 - s1_r.sy);
      s2_nxt.sy = cfg.ay0;
    end
    s2_nxt.rej = s1_r.rej || (s2_nxt.dx > cfg.cx1) || (s2_nxt.dy > cfg.cy1);
  end

  // Stage 3: cut the far edges at the destination clip end.
  always_comb begin
    s3_nxt = s2_r;
    ex = s2_r.dx + s2_r.w - bcs_pkg::calc_t'(1);
    ey = s2_r.dy + s2_r.h - bcs_pkg::calc_t'(1);
    if (ex > cfg.cx1) s3_nxt.w = s2_r.w - (ex - cfg.cx1);
    if (ey > cfg.cy1) s3_nxt.h = s2_r.h - (ey - cfg.cy1);
    s3_nxt.rej = s2_r.rej || (ex < cfg.cx0) || (ey < cfg.cy0)
              || (s3_nxt.w < bcs_pkg::calc_t'(1)) || (s3_nxt.h < bcs_pkg::calc_t'(1));
  end

  // Stage 4: cut the far edges at the source area end.
  always_comb begin
    s4_nxt = s3_r;
    if ((s3_r.sx + s3_r.w - bcs_pkg::calc_t'(1)) > cfg.ax1) begin
      s4_nxt.w = cfg.ax1 - s3_r.sx + bcs_pkg::calc_t'(1);
    end
    if ((s3_r.sy + s3_r.h - bcs_pkg::calc_t'(1)) > cfg.ay1) begin
      s4_nxt.h = cfg.ay1 - s3_r.sy + bcs_pkg::calc_t'(1);
    end
    s4_nxt.rej = s3_r.rej
              || ((s3_r.sx + s3_r.w - bcs_pkg::calc_t'(1)) < cfg.ax0)
              || ((s3_r.sy + s3_r.h - bcs_pkg::calc_t'(1)) < cfg.ay0)
              || (s4_nxt.w < bcs_pkg::calc_t'(1)) || (s4_nxt.h < bcs_pkg::calc_t'(1));
  end

  always_ff @(posedge clk) begin
    if (adv[0]) s0_r <= s0_nxt;
    if (adv[1]) s1_r <= s1_nxt;
    if (adv[2]) s2_r <= s2_nxt;
    if (adv[3]) s3_r <= s3_nxt;
    if (adv[4]) s4_r <= s4_nxt;
  end

  assign up_ready = adv[0];
  assign dn_valid = vld_r[NS-1];
  assign dn_cmd   = s4_r;

endmodule

### src/bcs_addr.sv
// Address pipeline of the blit clip setup block: row multiply, start index
// sums, equal-start reject and the output register. Uses bcs_pkg.
module bcs_addr (
  input  logic           clk,
  input  logic           rst_n,
  input  bcs_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  bcs_pkg::clip_t up_cmd,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bcs_pkg::res_t  dn_res
);

  localparam int NS = 3;

  typedef struct packed {
    bcs_pkg::prod_t dprod;
    bcs_pkg::prod_t sprod;
    bcs_pkg::calc_t dx;
    bcs_pkg::calc_t sx;
    bcs_pkg::calc_t w;
    bcs_pkg::calc_t h;
    logic           rej;
  } mul_t;

  typedef struct packed {
    bcs_pkg::addr_t ds;
    bcs_pkg::addr_t ss;
    bcs_pkg::size_t w;
    bcs_pkg::size_t h;
    bcs_pkg::skip_t dskip;
    bcs_pkg::skip_t sskip;
    logic           rej;
  } sum_t;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;
  mul_t          m_nxt, m_r;
  sum_t          a_nxt, a_r;
  bcs_pkg::res_t r_nxt, r_r;
  logic          rej_out;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_r[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 0: y times pitch, plus the last check that the destination
  // still reaches into the clip after the source cut.
  always_comb begin
    m_nxt.dprod = up_cmd.dy * $signed({1'b0, cfg.dpitch});
    m_nxt.sprod = up_cmd.sy * $signed({1'b0, cfg.spitch});
    m_nxt.dx    = up_cmd.dx;
    m_nxt.sx    = up_cmd.sx;
    m_nxt.w     = up_cmd.w;
    m_nxt.h     = up_cmd.h;
    m_nxt.rej   = up_cmd.rej
               || ((up_cmd.dx + up_cmd.w - bcs_pkg::calc_t'(1)) < cfg.cx0)
               || ((up_cmd.dy + up_cmd.h - bcs_pkg::calc_t'(1)) < cfg.cy0);
  end

  // Stage 1: base + row offset + x, wrapping at the address width.
  always_comb begin
    a_nxt.ds    = cfg.dbase + bcs_pkg::addr_t'(m_r.dprod) + bcs_pkg::addr_t'(m_r.dx);
    a_nxt.ss    = cfg.sbase + bcs_pkg::addr_t'(m_r.sprod) + bcs_pkg::addr_t'(m_r.sx);
    a_nxt.w     = bcs_pkg::size_t'(m_r.w);
    a_nxt.h     = bcs_pkg::size_t'(m_r.h);
    a_nxt.dskip = bcs_pkg::skip_t'(cfg.dpitch) - bcs_pkg::skip_t'(m_r.w);
    a_nxt.sskip = bcs_pkg::skip_t'(cfg.spitch) - bcs_pkg::skip_t'(m_r.w);
    a_nxt.rej   = m_r.rej;
  end

  // Stage 2: a copy onto itself is dropped; rejected results read all zero.
  always_comb begin
    rej_out = a_r.rej || (a_r.ds == a_r.ss);
    r_nxt   = '0;
    if (!rej_out) begin
      r_nxt.accepted       = 1'b1;
      r_nxt.dst_start      = bcs_pkg::pix_t'(a_r.ds);
      r_nxt.src_start      = bcs_pkg::pix_t'(a_r.ss);
      r_nxt.clipped_width  = a_r.w;
      r_nxt.clipped_height = a_r.h;
      r_nxt.dst_row_skip   = a_r.dskip;
      r_nxt.src_row_skip   = a_r.sskip;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) m_r <= m_nxt;
    if (adv[1]) a_r <= a_nxt;
    if (adv[2]) r_r <= r_nxt;
  end

  assign up_ready = adv[0];
  assign dn_valid = vld_r[NS-1];
  assign dn_res   = r_r;

endmodule

### src/bcs_checker.sv
// Port-level checker for the blit clip setup block, bound to the top level.
// Uses bcs_pkg and the macros of blit_clip_setup_assert.svh.
`include "blit_clip_setup_assert.svh"

module bcs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bcs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                     out_tuser
);

  logic [bcs_pkg::PIX_W-1:0]  dst_s;
  logic [bcs_pkg::PIX_W-1:0]  src_s;
  logic [bcs_pkg::SIZE_W-1:0] cw;
  logic [bcs_pkg::SIZE_W-1:0] ch;

  assign dst_s = out_tdata[bcs_pkg::OUT_DST_LSB +: bcs_pkg::PIX_W];
  assign src_s = out_tdata[bcs_pkg::OUT_SRC_LSB +: bcs_pkg::PIX_W];
  assign cw    = out_tdata[bcs_pkg::OUT_CW_LSB +: bcs_pkg::SIZE_W];
  assign ch    = out_tdata[bcs_pkg::OUT_CH_LSB +: bcs_pkg::SIZE_W];

  // Reset empties the pipeline, so no result is offered right after it.
  `BCS_ASSERT_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_tvalid, "result offered after reset")

  // A stalled result holds still.
  `BCS_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // A rejected command reads as all zero.
  `BCS_ASSERT(a_reject_zero, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "rejected result not zero")

  // A remaining copy has a nonempty size and distinct start indexes.
  `BCS_ASSERT(a_accept_sane, out_tvalid && out_tuser[0] |-> cw != '0 && ch != '0 && dst_s != src_s, "accepted result inconsistent")

endmodule

bind blit_clip_setup bcs_checker u_bcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for blit_clip_setup: directed commands, then random
// commands under several register settings, checked against a predictor.
// Depends on bcs_pkg and the blit_clip_setup RTL.
module testbench;
  import bcs_pkg::*;

  // Eight pipeline stages from a command transfer to its result.
  localparam int PIPE_LATENCY  = 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_REPORTS   = 50;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 236;

  // Register index past the end of the register file; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // One command as it travels on in_tdata. A packed struct puts its first
  // member in the top bits, so dest_x is declared last to land in bits 15:0.
  typedef struct packed {
    crd_t h;
    crd_t w;
    crd_t sy;
    crd_t sx;
    crd_t dy;
    crd_t dx;
  } cmd_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // One row of the directed sequence: a command or a register write. A command
  // row either carries its expected result or leaves it to the predictor.
  typedef struct packed {
    row_kind_t            kind;
    cmd_t                 cmd;
    logic                 typed;
    res_t                 want;
    logic [CFG_IDX_W-1:0] idx;
    cfg_word_t            value;
  } plan_row_t;

  // Shapes of the random register settings.
  typedef enum logic [1:0] {SET_WINDOW, SET_ALIASED, SET_NOISE, SET_EXTREME} setting_t;

  // Patterns of the receiver's backpressure.
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  cfg_word_t             cfg_data;

  // The register file as the block should hold it, updated on each write
  // transfer, and the next setting to be loaded.
  cfg_word_t cfg_regs [NUM_REGS];
  cfg_word_t next_cfg [NUM_REGS];

  // Results still owed by the block, oldest first.
  res_t      pending_copies [$];
  plan_row_t directed_rows [$];

  // Set by the driver with each command; a typed row overrides the predictor.
  logic typed_valid;
  res_t typed_want;

  int mismatch_count;
  int result_count;
  int cycle_count;

  setting_t phase_plan [RANDOM_PHASES] = '{SET_WINDOW, SET_ALIASED, SET_NOISE, SET_WINDOW,
                                           SET_EXTREME, SET_ALIASED, SET_WINDOW};

  blit_clip_setup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic cfg_word_t pack_xy(int x, int y);
    return {16'(y), 16'(x)};
  endfunction

  function automatic cmd_t make_cmd(int dx, int dy, int sx, int sy, int w, int h);
    cmd_t c;
    c.dx = crd_t'(dx);
    c.dy = crd_t'(dy);
    c.sx = crd_t'(sx);
    c.sy = crd_t'(sy);
    c.w  = crd_t'(w);
    c.h  = crd_t'(h);
    return c;
  endfunction

  // Clips one command against the current registers and works out the result
  // the block owes for it. All coordinates are held at 64 bits so that no
  // intermediate sum wraps; only the final fields are cut to port widths.
  function automatic res_t clip_copy(cmd_t c);
    longint dx, dy, sx, sy, w, h, e;
    longint cx0, cy0, cx1, cy1, ax0, ay0, ax1, ay1, dpitch, spitch;
    pix_t ds, ss;
    res_t r;
    r   = '0;
    dx  = c.dx;
    dy  = c.dy;
    sx  = c.sx;
    sy  = c.sy;
    w   = c.w;
    h   = c.h;
    cx0 = $signed(cfg_regs[REG_DST_CLIP_START][15:0]);
    cy0 = $signed(cfg_regs[REG_DST_CLIP_START][31:16]);
    cx1 = $signed(cfg_regs[REG_DST_CLIP_END][15:0]);
    cy1 = $signed(cfg_regs[REG_DST_CLIP_END][31:16]);
    ax0 = $signed(cfg_regs[REG_SRC_AREA_ORIGIN][15:0]);
    ay0 = $signed(cfg_regs[REG_SRC_AREA_ORIGIN][31:16]);
    ax1 = ax0 + longint'(cfg_regs[REG_SRC_AREA_SIZE][15:0]) - 1;
    ay1 = ay0 + longint'(cfg_regs[REG_SRC_AREA_SIZE][31:16]) - 1;
    dpitch = longint'(cfg_regs[REG_ROW_PITCHES][15:0]);
    spitch = longint'(cfg_regs[REG_ROW_PITCHES][31:16]);

    if (dx > cx1 || dy > cy1 || sx > ax1 || sy > ay1) return r;

    // Move the top-left corner in: destination clip first, then source area.
    if (dx < cx0) begin
      w  -= cx0 - dx;
      sx += cx0 - dx;
      dx  = cx0;
    end
    if (sx > ax1) return r;
    if (sx < ax0) begin
      w  -= ax0 - sx;
      dx += ax0 - sx;
      sx  = ax0;
    end
    if (dx > cx1) return r;

    if (dy < cy0) begin
      h  -= cy0 - dy;
      sy += cy0 - dy;
      dy  = cy0;
    end
    if (sy > ay1) return r;
    if (sy < ay0) begin
      h  -= ay0 - sy;
      dy += ay0 - sy;
      sy  = ay0;
    end
    if (dy > cy1) return r;

    // Then trim the far edges, again destination before source.
    e = dx + w - 1;
    if (e < cx0) return r;
    if (e > cx1) w -= e - cx1;
    if (w <= 0) return r;
    e = sx + w - 1;
    if (e < ax0) return r;
    if (e > ax1) w -= e - ax1;
    if (w <= 0) return r;
    if (dx + w - 1 < cx0) return r;

    e = dy + h - 1;
    if (e < cy0) return r;
    if (e > cy1) h -= e - cy1;
    if (h <= 0) return r;
    e = sy + h - 1;
    if (e < ay0) return r;
    if (e > ay1) h -= e - ay1;
    if (h <= 0) return r;
    if (dy + h - 1 < cy0) return r;

    ds = cfg_regs[REG_DST_BASE] + pix_t'(dy * dpitch + dx);
    ss = cfg_regs[REG_SRC_BASE] + pix_t'(sy * spitch + sx);
    // A copy onto itself is dropped.
    if (ds == ss) return r;

    r.accepted       = 1'b1;
    r.dst_start      = ds;
    r.src_start      = ss;
    r.clipped_width  = size_t'(w);
    r.clipped_height = size_t'(h);
    r.dst_row_skip   = skip_t'(dpitch - w);
    r.src_row_skip   = skip_t'(spitch - w);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic compare_copy(input res_t got, input res_t want, input int n);
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("result %0d accepted: got %0h, expected %0h",
                                n, got.accepted, want.accepted));
    if (got.dst_start !== want.dst_start)
      report_mismatch($sformatf("result %0d dst_start: got %0h, expected %0h",
                                n, got.dst_start, want.dst_start));
    if (got.src_start !== want.src_start)
      report_mismatch($sformatf("result %0d src_start: got %0h, expected %0h",
                                n, got.src_start, want.src_start));
    if (got.clipped_width !== want.clipped_width)
      report_mismatch($sformatf("result %0d clipped_width: got %0h, expected %0h",
                                n, got.clipped_width, want.clipped_width));
    if (got.clipped_height !== want.clipped_height)
      report_mismatch($sformatf("result %0d clipped_height: got %0h, expected %0h",
                                n, got.clipped_height, want.clipped_height));
    if (got.dst_row_skip !== want.dst_row_skip)
      report_mismatch($sformatf("result %0d dst_row_skip: got %0h, expected %0h",
                                n, got.dst_row_skip, want.dst_row_skip));
    if (got.src_row_skip !== want.src_row_skip)
      report_mismatch($sformatf("result %0d src_row_skip: got %0h, expected %0h",
                                n, got.src_row_skip, want.src_row_skip));
  endtask

  // All three channels are watched at the rising edge, where the values seen
  // are those driven at the falling edge before. A register write updates the
  // local copy, a command transfer queues its result, and a result transfer
  // is checked against the oldest queued one.
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) cfg_regs[cfg_index] = cfg_data;
      if (in_tvalid && in_tready)
        pending_copies.push_back(typed_valid ? typed_want : clip_copy(cmd_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got.accepted       = out_tuser[0];
        got.dst_start      = out_tdata[OUT_DST_LSB +: PIX_W];
        got.src_start      = out_tdata[OUT_SRC_LSB +: PIX_W];
        got.clipped_width  = out_tdata[OUT_CW_LSB +: SIZE_W];
        got.clipped_height = out_tdata[OUT_CH_LSB +: SIZE_W];
        got.dst_row_skip   = out_tdata[OUT_DSK_LSB +: SKIP_W];
        got.src_row_skip   = out_tdata[OUT_SSK_LSB +: SKIP_W];
        if (pending_copies.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding", result_count));
        end else begin
          want = pending_copies.pop_front();
          compare_copy(got, want, result_count);
        end
        result_count++;
      end
    end
  end

  // The receiver switches between backpressure patterns at random intervals:
  // always ready, a coin toss, mostly stalled, and a fixed rhythm.
  initial begin : receiver
    stall_t mode;
    int     left;
    out_tready = 1'b0;
    mode       = STALL_NONE;
    left       = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_t'($urandom_range(0, 3));
        left = pick(16, 160);
      end
      left--;
      case (mode)
        STALL_NONE:  out_tready <= 1'b1;
        STALL_COIN:  out_tready <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_tready <= ($urandom_range(0, 4) == 0);
        default:     out_tready <= ((left % 7) < 3);
      endcase
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  // Drives one command and holds it until the block takes it. Valid is left
  // high so that back-to-back commands need no second assignment.
  task automatic send_cmd(input cmd_t c, input logic typed, input res_t want);
    @(negedge clk);
    in_tvalid   <= 1'b1;
    in_tdata    <= c;
    typed_valid  = typed;
    typed_want   = want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stops sending and waits for every owed result. Before a register write
  // the pipeline is also given its full depth to go quiet.
  task automatic settle(input logic with_pause);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_copies.size() != 0) @(posedge clk);
    if (with_pause) repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Writes the whole prepared setting, then a junk word to the index past the
  // register file, which must leave every register as it is.
  task automatic load_config();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), next_cfg[i]);
    write_reg(REG_NONE, $urandom());
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_cmd(int dx, int dy, int sx, int sy, int w, int h,
                                  logic typed, res_t want);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CMD;
    row.cmd   = make_cmd(dx, dy, sx, sy, w, h);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, cfg_word_t value);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.value = value;
    directed_rows.push_back(row);
  endfunction

  task automatic build_directed();
    res_t rejected;
    res_t small_copy;
    rejected   = '0;
    small_copy = '{1'b1, 32'h0000_290A, 32'h0000_784E, 15'd5, 15'd3, 16'd315, 16'd59};

    // Out of reset the source area has zero size, so nothing gets through.
    add_cmd(0, 0, 0, 0, 1, 1, 1'b1, rejected);
    add_cmd(32767, 32767, 32767, 32767, 32767, 32767, 1'b1, rejected);
    add_cmd(-32768, -32768, -32768, -32768, 32767, 32767, 1'b1, rejected);

    // Clip window (10,20)..(100,80); source area (-50,-30), 60 by 40.
    add_cfg(REG_DST_CLIP_START,  pack_xy(10, 20));
    add_cfg(REG_DST_CLIP_END,    pack_xy(100, 80));
    add_cfg(REG_SRC_AREA_ORIGIN, pack_xy(-50, -30));
    add_cfg(REG_SRC_AREA_SIZE,   pack_xy(60, 40));
    add_cfg(REG_ROW_PITCHES,     {16'd64, 16'd320});
    add_cfg(REG_DST_BASE,        32'h0000_1000);
    add_cfg(REG_SRC_BASE,        32'h0000_8000);
    add_cfg(REG_NONE,            32'hFFFF_FFFF);
    add_cmd(10, 20, -50, -30, 5, 3, 1'b1, small_copy);
    add_cmd(10, 20, -50, -30, 0, 3, 1'b1, rejected);
    add_cmd(10, 20, -50, -30, 5, -5, 1'b1, rejected);
    add_cmd(32767, 20, -50, -30, 5, 3, 1'b1, rejected);
    add_cmd(10, 20, -50, 32767, 5, 3, 1'b1, rejected);
    add_cmd(-32768, -32768, -32768, -32768, 32767, 32767, 1'b0, rejected);
    // Source corner left of and above the area; far edges past both rectangles.
    add_cmd(0, 0, -60, -40, 200, 200, 1'b0, rejected);
    add_cmd(95, 75, 5, 5, 50, 50, 1'b0, rejected);

    // Same pitch and base on both sides: equal corners land on one pixel.
    add_cfg(REG_DST_CLIP_START,  pack_xy(0, 0));
    add_cfg(REG_DST_CLIP_END,    pack_xy(1000, 1000));
    add_cfg(REG_SRC_AREA_ORIGIN, pack_xy(0, 0));
    add_cfg(REG_SRC_AREA_SIZE,   pack_xy(1000, 1000));
    add_cfg(REG_ROW_PITCHES,     {16'd100, 16'd100});
    add_cfg(REG_DST_BASE,        32'h0000_0000);
    add_cfg(REG_SRC_BASE,        32'h0000_0000);
    add_cmd(5, 7, 5, 7, 10, 10, 1'b1, rejected);
    add_cmd(5, 7, 6, 7, 10, 10, 1'b0, rejected);

    // Clip start beyond its end rejects everything.
    add_cfg(REG_DST_CLIP_START, pack_xy(50, 50));
    add_cfg(REG_DST_CLIP_END,   pack_xy(40, 40));
    add_cmd(0, 0, 100, 100, 100, 100, 1'b1, rejected);

    // Full coordinate range, pitches at both ends, bases that wrap.
    add_cfg(REG_DST_CLIP_START,  pack_xy(-32768, -32768));
    add_cfg(REG_DST_CLIP_END,    pack_xy(32767, 32767));
    add_cfg(REG_SRC_AREA_ORIGIN, pack_xy(-32768, -32768));
    add_cfg(REG_SRC_AREA_SIZE,   32'hFFFF_FFFF);
    add_cfg(REG_ROW_PITCHES,     {16'hFFFF, 16'h0000});
    add_cfg(REG_DST_BASE,        32'hFFFF_FFFF);
    add_cfg(REG_SRC_BASE,        32'h0000_0001);
    add_cmd(-32768, -32768, -32768, -32768, 32767, 32767, 1'b0, rejected);
    add_cmd(32767, 32767, 32766, 32766, 1, 1, 1'b0, rejected);
    add_cmd(0, 0, 100, -5, 32767, 1, 1'b0, rejected);
    add_cmd(-1, -1, -1, -1, -32768, -32768, 1'b1, rejected);
  endtask

  task automatic run_directed();
    logic in_cfg;
    res_t none;
    in_cfg = 1'b0;
    none   = '0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!in_cfg) settle(1'b1);
        write_reg(directed_rows[i].idx, directed_rows[i].value);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          @(negedge clk);
          cfg_valid <= 1'b0;
        end
        in_cfg = 1'b0;
        send_cmd(directed_rows[i].cmd, directed_rows[i].typed,
                 directed_rows[i].typed ? directed_rows[i].want : none);
      end
    end
  endtask

  function automatic logic [15:0] pick_pitch();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'(pick(1, 640));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cfg_word_t pick_base();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_extent();
    return ($urandom_range(0, 15) == 0) ? 0 : pick(1, 400);
  endfunction

  // Most sizes are small; some span the clip window, a few are anything.
  function automatic int pick_size(int span);
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: return pick(-2, 64);
      5, 6:          return pick(1, span + 50);
      default:       return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic roll_config(input setting_t s);
    int          cx0;
    int          cy0;
    logic [15:0] pitch;
    case (s)
      SET_WINDOW, SET_ALIASED: begin
        cx0 = pick(-300, 300);
        cy0 = pick(-300, 300);
        // The far corner sometimes lands before the start: an empty window.
        next_cfg[REG_DST_CLIP_START]  = pack_xy(cx0, cy0);
        next_cfg[REG_DST_CLIP_END]    = pack_xy(cx0 + pick(-3, 400), cy0 + pick(-3, 300));
        next_cfg[REG_SRC_AREA_ORIGIN] = pack_xy(pick(-300, 300), pick(-300, 300));
        next_cfg[REG_SRC_AREA_SIZE]   = pack_xy(pick_extent(), pick_extent());
        next_cfg[REG_ROW_PITCHES]     = {pick_pitch(), pick_pitch()};
        next_cfg[REG_DST_BASE]        = pick_base();
        next_cfg[REG_SRC_BASE]        = pick_base();
        if (s == SET_ALIASED) begin
          // Source overlays the destination, so copies onto themselves occur.
          pitch = pick_pitch();
          next_cfg[REG_SRC_AREA_ORIGIN] = next_cfg[REG_DST_CLIP_START];
          next_cfg[REG_SRC_AREA_SIZE]   = pack_xy(pick(1, 400), pick(1, 300));
          next_cfg[REG_ROW_PITCHES]     = {pitch, pitch};
          next_cfg[REG_SRC_BASE]        = next_cfg[REG_DST_BASE];
        end
      end
      SET_NOISE: begin
        foreach (next_cfg[i]) next_cfg[i] = $urandom();
      end
      default: begin
        next_cfg[REG_DST_CLIP_START]  = pack_xy(-32768, -32768);
        next_cfg[REG_DST_CLIP_END]    = pack_xy(32767, 32767);
        next_cfg[REG_SRC_AREA_ORIGIN] = pack_xy(-32768, -32768);
        next_cfg[REG_SRC_AREA_SIZE]   = 32'hFFFF_FFFF;
        next_cfg[REG_ROW_PITCHES]     = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                         $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
        next_cfg[REG_DST_BASE]        = 32'hFFFF_FFFF;
        next_cfg[REG_SRC_BASE]        = $urandom_range(0, 1) ? 32'h0000_0000 : $urandom();
      end
    endcase
  endtask

  // A quarter of the commands are pure noise. The rest place both corners
  // around the edges of the current clip window and source area, so that
  // every clipping step is reached, and now and then reuse the destination
  // corner as the source corner.
  function automatic cmd_t random_cmd();
    int   cx0, cy0, cx1, cy1, ax0, ay0, ax1, ay1;
    int   dx, dy, sx, sy;
    cmd_t c;
    if ($urandom_range(0, 3) == 0) begin
      c = {$urandom(), $urandom(), $urandom()};
      return c;
    end
    cx0 = $signed(cfg_regs[REG_DST_CLIP_START][15:0]);
    cy0 = $signed(cfg_regs[REG_DST_CLIP_START][31:16]);
    cx1 = $signed(cfg_regs[REG_DST_CLIP_END][15:0]);
    cy1 = $signed(cfg_regs[REG_DST_CLIP_END][31:16]);
    ax0 = $signed(cfg_regs[REG_SRC_AREA_ORIGIN][15:0]);
    ay0 = $signed(cfg_regs[REG_SRC_AREA_ORIGIN][31:16]);
    ax1 = ax0 + int'(cfg_regs[REG_SRC_AREA_SIZE][15:0]) - 1;
    ay1 = ay0 + int'(cfg_regs[REG_SRC_AREA_SIZE][31:16]) - 1;
    dx  = pick(cx0 - 40, cx1 + 8);
    dy  = pick(cy0 - 40, cy1 + 8);
    sx  = pick(ax0 - 40, ax1 + 8);
    sy  = pick(ay0 - 40, ay1 + 8);
    if ($urandom_range(0, 5) == 0) begin
      sx = dx;
      sy = dy;
    end
    return make_cmd(dx, dy, sx, sy, pick_size(cx1 - cx0), pick_size(cy1 - cy0));
  endfunction

  // Reset, the directed sequence, then the random phases. Each phase loads
  // a new setting while the block is empty and then streams commands in
  // bursts of random length separated by random gaps.
  initial begin : stimulus
    int   burst_left;
    int   gap;
    res_t none;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    typed_valid    = 1'b0;
    typed_want     = '0;
    none           = '0;
    mismatch_count = 0;
    result_count   = 0;
    burst_left     = 0;
    foreach (cfg_regs[i]) cfg_regs[i] = '0;
    build_directed();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle(1'b1);
      roll_config(phase_plan[p]);
      load_config();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? pick(40, 120) : pick(1, 24);
          gap = ($urandom_range(0, 4) == 0) ? 0
              : pick(1, ($urandom_range(0, 3) == 0) ? 20 : 4);
          repeat (gap) begin
            @(negedge clk);
            in_tvalid <= 1'b0;
          end
        end
        burst_left--;
        // Once mid-run, let the pipeline empty completely before going on.
        if (p == 3 && i == PHASE_ITEMS / 2) settle(1'b0);
        send_cmd(random_cmd(), 1'b0, none);
      end
    end

    settle(1'b1);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
